// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, helper functions and the controller
// to datapath command and status types.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos  = 56;
  localparam logic [7:0]  PadMark    = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD_ROUND,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_byte;   // store the input byte and count it
    logic       pad_load;    // build the padded word for round load
    logic       pad_second;  // this is the length-only second pad block
    logic       round_start; // load working variables from the chain
    logic       round_step;  // run one compression round
    logic       fold;        // add working variables into the chain
    logic       emit_clear;  // reset the message state after output
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       block_full;  // the taken byte completed a block
    logic       rounds_done; // round 63, the last, is running
    logic       need_extra;  // padding does not fit in the current block
  } sha_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[idx];
  endfunction

endpackage

// ===== src/sha_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, block compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      last_byte_i,
  input  logic      no_byte_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [2:0] word_number_o,
  output logic      final_word_o,
  input  sha_stat_t stat_i,
  output sha_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        last_q, last_d;     // message closes after the current block
  logic        padded_q, padded_d; // the running block already holds padding
  logic        extra_q, extra_d;   // the length-only second block has run
  logic [2:0]  word_q, word_d;
  logic        accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    padded_d = padded_q;
    extra_d  = extra_q;
    word_d   = word_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d   = last_byte_i;
          padded_d = 1'b0;
          extra_d  = 1'b0;
          if (!no_byte_i && stat_i.block_full) begin
            state_d = ST_ROUND;
          end else if (last_byte_i) begin
            state_d  = ST_PAD_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (stat_i.rounds_done) state_d = ST_FOLD;
      end
      ST_PAD_ROUND: begin
        state_d = ST_ROUND;
        padded_d = 1'b1;
        extra_d  = padded_q;
      end
      ST_FOLD: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!padded_q) begin
          state_d = ST_PAD_ROUND;
        end else if (stat_i.need_extra && !extra_q) begin
          state_d = ST_PAD_ROUND;
        end else begin
          state_d = ST_EMIT;
          word_d  = 3'd0;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          word_d = word_q + 3'd1;
          if (word_q == 3'd7) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.take_byte   = accept && !no_byte_i;
    cmd_o.round_start = 1'b0;
    unique case (state_q)
      ST_IDLE:      cmd_o.round_start = accept && !no_byte_i && stat_i.block_full;
      ST_ROUND:     cmd_o.round_step = 1'b1;
      ST_PAD_ROUND: begin
        cmd_o.pad_load    = 1'b1;
        cmd_o.pad_second  = padded_q;
        cmd_o.round_start = 1'b1;
      end
      ST_FOLD:      cmd_o.fold = 1'b1;
      ST_EMIT:      cmd_o.emit_clear = !out_stall_i && (word_q == 3'd7);
      default:      ;
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign word_number_o = word_q;
  assign final_word_o  = (word_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      last_q   <= 1'b0;
      padded_q <= 1'b0;
      extra_q  <= 1'b0;
      word_q   <= 3'd0;
    end else begin
      state_q  <= state_d;
      last_q   <= last_d;
      padded_q <= padded_d;
      extra_q  <= extra_d;
      word_q   <= word_d;
    end
  end

endmodule

// ===== src/sha_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window that also collects the block bytes, working
// variables and chain words.
// ----------------------------------------------------------------------------
module sha_dpath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  message_byte_i,
  input  logic [2:0]  word_sel_i,
  input  sha_cmd_t    cmd_i,
  output sha_stat_t   stat_o,
  output logic [31:0] digest_word_o
);

  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [31:0] chain_q [8];
  logic [31:0] var_q [8];
  logic [31:0] w_q [16];             // sliding schedule window, filled byte by byte
  logic [5:0]  rnd_q;
  logic        fill_wrap;
  logic        need_extra;
  logic [63:0] bit_len;
  logic [31:0] load_w [16];
  logic [31:0] w_new, t1, t2, s0, s1, e, a, wr;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign fill_wrap  = (fill_q == 6'd63);
  assign need_extra = (fill_q >= 6'(LengthPos)) && !cmd_i.pad_second;
  assign bit_len    = {total_q, 3'b000};

  // Padded block image. The first padded block keeps the bytes below the fill
  // level, then the mark and zero fill; the length goes in when it fits. The
  // second block holds zeros and the length only.
  always_comb begin
    logic [7:0] b;
    logic [5:0] idx;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        idx = 6'(4 * i + j);
        b   = 8'h00;
        if (!cmd_i.pad_second) begin
          if (idx < fill_q) b = w_q[i][8 * (3 - j) +: 8];
          else if (idx == fill_q) b = PadMark;
        end
        if (!need_extra && idx >= 6'(LengthPos))
          b = bit_len[6'(8 * (63 - int'(idx))) +: 8];
        load_w[i][8 * (3 - j) +: 8] = b;
      end
    end
  end

  assign stat_o.block_full  = fill_wrap;
  assign stat_o.need_extra  = need_extra;
  assign stat_o.rounds_done = (rnd_q == 6'd63);

  assign s0    = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign wr    = w_q[0];
  assign e     = var_q[4];
  assign a     = var_q[0];
  assign t1 = var_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) +
              ((e & var_q[5]) ^ (~e & var_q[6])) + round_k(rnd_q) + wr;
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) +
              ((a & var_q[1]) ^ (a & var_q[2]) ^ (var_q[1] & var_q[2]));

  // Bytes land big-endian in the window; the byte that completes a block is
  // written at the same edge as the round start, so the window is whole then.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= message_byte_i;
    if (cmd_i.round_start) begin
      if (cmd_i.pad_load) begin
        for (int i = 0; i < 16; i++) w_q[i] <= load_w[i];
      end
      for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_new;
      for (int i = 1; i < 8; i++) var_q[i] <= var_q[i - 1];
      var_q[4] <= var_q[3] + t1;
      var_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
    end else begin
      if (cmd_i.take_byte) begin
        fill_q  <= fill_q + 6'd1;
        total_q <= total_q + 61'd1;
      end
      if (cmd_i.round_start) rnd_q <= '0;
      else if (cmd_i.round_step) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
      end
      if (cmd_i.emit_clear) begin
        fill_q  <= '0;
        total_q <= '0;
        for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
      end
    end
  end

  assign digest_word_o = chain_q[word_sel_i];

endmodule

// ===== src/sha256_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Bytes are taken one per item, none for an item flagged no_byte, while the
// current 64-byte block is filling. The item that completes a block holds the
// input off for 64 compression rounds, one per cycle in the shared round
// unit, and a fold step that adds the result into the chaining words. An item
// marked last adds one or two padding blocks, each a pad load step, the
// rounds and a fold, after which the eight digest words are offered one per
// cycle while out_stall_i is low, word 0 first, and the block returns to its
// initial state for the next message.
module sha256_stream_hasher_core import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        last_byte_i,
  input  logic        no_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        final_word_o
);

  sha_cmd_t  cmd;
  sha_stat_t stat;

  // The controller decides when bytes enter and when rounds and output run.
  sha_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .last_byte_i,
    .no_byte_i,
    .out_valid_o,
    .out_stall_i,
    .word_number_o,
    .final_word_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // The datapath holds the block, the schedule window and the chain.
  sha_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .message_byte_i,
    .word_sel_i    (word_number_o),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o
  );

endmodule

// ===== src/sha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top level's ports for input/output exclusion and for ordering of the digest words.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] word_number_o,
  input logic       final_word_o
);

  // Input and output never run at once.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during output");

  // An item just taken is never followed straight away by digest output.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("output right after an input item");

  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_word_o == (word_number_o == 3'd7)))
    else $error("final flag mismatch");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !final_word_o) |=>
      (out_valid_o && word_number_o == $past(word_number_o) + 3'd1))
    else $error("digest word order broken");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_number_o == 3'd0))
    else $error("digest does not start at word 0");

endmodule

bind sha256_stream_hasher_core sha_checker u_sha_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .word_number_o, .final_word_o
);
